@@ rtl/core/lpc_pkg.sv @@
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants of the lidar point colorizer
// Register indexes, field widths, status codes and pipeline side-band type.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

  localparam int unsigned IMAGE_PIXELS = 4194304;
  localparam int unsigned IMAGE_PIXELS_MAX = 16777216;

  // configuration register indexes
  localparam logic [2:0] REG_ROT_ROW0   = 3'd0;
  localparam logic [2:0] REG_ROT_ROW1   = 3'd1;
  localparam logic [2:0] REG_ROT_ROW2   = 3'd2;
  localparam logic [2:0] REG_SHIFT      = 3'd3;
  localparam logic [2:0] REG_FOCAL      = 3'd4;
  localparam logic [2:0] REG_PRINCIPAL  = 3'd5;
  localparam logic [2:0] REG_WIDTH      = 3'd6;
  localparam logic [2:0] REG_HEIGHT     = 3'd7;

  localparam int unsigned CFG_W = 63;

  // status codes
  localparam logic [1:0] ST_COLORED  = 2'd0;
  localparam logic [1:0] ST_ZERO_PT  = 2'd1;
  localparam logic [1:0] ST_NO_COLOR = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  // extrinsic depth offset, 0.1 m in Q14.10
  localparam logic signed [24:0] DEPTH_OFFSET = 25'sd102;

  // divider: |numerator| >> 10 fits 39 bits, |depth| fits 24 bits
  localparam int unsigned NUM_W = 39;
  localparam int unsigned DEN_W = 24;

  // side-band that travels along the divider
  typedef struct packed {
    logic               valid;
    logic               cmd;
    logic [21:0]        pixel_index;
    logic [23:0]        pixel_color;
    logic               zero_pt;
    logic               depth_zero;
    logic signed [23:0] wx;
    logic signed [23:0] wy;
    logic signed [23:0] wz;
    logic               neg_u;
    logic               neg_v;
  } side_t;

endpackage

`default_nettype wire

@@ rtl/core/lpc_ram.sv @@
// ----------------------------------------------------------------------------
// lpc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, both gated by en.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lpc_div.sv @@
// ----------------------------------------------------------------------------
// lpc_div: pipelined unsigned restoring divider
// One quotient bit per stage, NUM_W stages, whole pipe advances on en.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_div #(
  parameter int unsigned NUM_W = lpc_pkg::NUM_W,
  parameter int unsigned DEN_W = lpc_pkg::DEN_W
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] n_q [NUM_W+1];
  logic [NUM_W-1:0] q_q [NUM_W+1];
  logic [DEN_W-1:0] r_q [NUM_W+1];
  logic [DEN_W-1:0] d_q [NUM_W+1];

  assign n_q[0] = num;
  assign q_q[0] = '0;
  assign r_q[0] = '0;
  assign d_q[0] = den;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           fits;

    assign trial = {r_q[i], n_q[i][NUM_W-1]};
    assign fits  = (trial >= {1'b0, d_q[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[i+1] <= n_q[i] << 1;
        q_q[i+1] <= {q_q[i][NUM_W-2:0], fits};
        r_q[i+1] <= fits ? DEN_W'(trial - {1'b0, d_q[i]}) : trial[DEN_W-1:0];
        d_q[i+1] <= d_q[i];
      end
    end
  end

  assign quo = q_q[NUM_W];

endmodule

`default_nettype wire

@@ rtl/core/lidar_point_colorizer.sv @@
// ----------------------------------------------------------------------------
// lidar_point_colorizer: colors lidar points from a stored camera image
// Streaming top level: pixel loads, pinhole projection, color lookup.
// ----------------------------------------------------------------------------
// A request with tuser = 0 loads one 24-bit pixel into the image store and
// gives no result; tuser = 1 projects one lidar point and gives exactly one
// result. The block takes one request per clock while the result stream is
// not held; the 39-stage pipelined depth divider (one quotient bit per stage)
// lies between the projection stages and the index and memory stages.
// Loads and projections pass through the same pipe, so a load is seen by
// every later projection. The image store needs no clearing pass; a
// pixel that was never loaded reads back arbitrary data. Write config
// registers only while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_colorizer #(
  parameter int unsigned IMAGE_PIXELS = lpc_pkg::IMAGE_PIXELS,
  localparam int unsigned AW = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // config write port
  input  wire logic                     cfg_we,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [lpc_pkg::CFG_W-1:0] cfg_data,
  // request stream
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel_index[21:0], pixel_color[45:22], point_x[69:46],
  // point_y[93:70], point_z[117:94], zero pad [119:118]
  input  wire logic [119:0]             s_axis_tdata,
  input  wire logic                     s_axis_tuser,   // cmd
  // result stream
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // world_x[23:0], world_y[47:24], world_z[71:48],
  // color_ch0[79:72], color_ch1[87:80], color_ch2[95:88]
  output logic [95:0]                   m_axis_tdata,
  output logic [1:0]                    m_axis_tuser    // status
);

  localparam int unsigned NW = lpc_pkg::NUM_W;
  localparam int unsigned DW = lpc_pkg::DEN_W;

  // ---------------- configuration ----------------
  logic [47:0] rot0, rot1, rot2, focal, principal;
  logic [62:0] shift;
  logic [12:0] width, height;
  logic [25:0] area;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot0      <= '0;
      rot1      <= '0;
      rot2      <= '0;
      shift     <= '0;
      focal     <= '0;
      principal <= '0;
      width     <= 13'd1;
      height    <= 13'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpc_pkg::REG_ROT_ROW0:  rot0      <= cfg_data[47:0];
        lpc_pkg::REG_ROT_ROW1:  rot1      <= cfg_data[47:0];
        lpc_pkg::REG_ROT_ROW2:  rot2      <= cfg_data[47:0];
        lpc_pkg::REG_SHIFT:     shift     <= cfg_data[62:0];
        lpc_pkg::REG_FOCAL:     focal     <= cfg_data[47:0];
        lpc_pkg::REG_PRINCIPAL: principal <= cfg_data[47:0];
        lpc_pkg::REG_WIDTH:     width     <= cfg_data[12:0];
        lpc_pkg::REG_HEIGHT:    height    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // image area; the user changes it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    area <= width * height;
  end

  // ---------------- pipe control ----------------
  // whole pipe moves together; it only holds when a result waits
  logic advance;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  // ---------------- stage 1: capture ----------------
  logic               s1_valid, s1_cmd;
  logic [21:0]        s1_index;
  logic [23:0]        s1_color;
  logic signed [23:0] s1_x, s1_y, s1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd   <= s_axis_tuser;
      s1_index <= s_axis_tdata[21:0];
      s1_color <= s_axis_tdata[45:22];
      s1_x     <= s_axis_tdata[69:46];
      s1_y     <= s_axis_tdata[93:70];
      s1_z     <= s_axis_tdata[117:94];
    end
  end

  // ---------------- stage 2: products ----------------
  // camera frame: cam = (-y, -z, x + 0.1 m)
  logic signed [24:0] camx, camy, camz;
  assign camx = -25'(s1_y);
  assign camy = -25'(s1_z);
  assign camz = 25'(s1_x) + lpc_pkg::DEPTH_OFFSET;

  logic signed [39:0] wp_next [3][3];
  logic signed [23:0] coord [3];
  assign coord[0] = s1_x;
  assign coord[1] = s1_y;
  assign coord[2] = s1_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wp_next[0][c] = $signed(rot0[16*c +: 16]) * coord[c];
      wp_next[1][c] = $signed(rot1[16*c +: 16]) * coord[c];
      wp_next[2][c] = $signed(rot2[16*c +: 16]) * coord[c];
    end
  end

  logic               s2_valid, s2_cmd, s2_zero;
  logic [21:0]        s2_index;
  logic [23:0]        s2_color;
  logic signed [24:0] s2_camz;
  logic signed [49:0] s2_mu1, s2_mu2, s2_mv1, s2_mv2;
  logic signed [39:0] s2_wp [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cmd   <= s1_cmd;
      s2_zero  <= (s1_x == '0) && (s1_y == '0) && (s1_z == '0);
      s2_index <= s1_index;
      s2_color <= s1_color;
      s2_camz  <= camz;
      s2_mu1   <= $signed({1'b0, focal[23:0]}) * camx;
      s2_mu2   <= $signed({1'b0, principal[23:0]}) * camz;
      s2_mv1   <= $signed({1'b0, focal[47:24]}) * camy;
      s2_mv2   <= $signed({1'b0, principal[47:24]}) * camz;
      s2_wp    <= wp_next;
    end
  end

  // ---------------- stage 3: sums, world rounding ----------------
  logic signed [23:0] world_next [3];

  always_comb begin
    logic signed [42:0] acc;
    logic signed [28:0] rnd;
    for (int r = 0; r < 3; r++) begin
      acc = 43'(s2_wp[r][0]) + 43'(s2_wp[r][1]) + 43'(s2_wp[r][2])
          + (43'($signed(shift[21*r +: 21])) <<< 14) + 43'sd8192;
      rnd = 29'(acc >>> 14);
      if (rnd > 29'sd8388607) begin
        world_next[r] = 24'sh7FFFFF;
      end else if (rnd < -29'sd8388608) begin
        world_next[r] = 24'sh800000;
      end else begin
        world_next[r] = rnd[23:0];
      end
    end
  end

  logic               s3_valid, s3_cmd, s3_zero;
  logic [21:0]        s3_index;
  logic [23:0]        s3_color;
  logic signed [24:0] s3_camz;
  logic signed [50:0] s3_nu, s3_nv;
  logic signed [23:0] s3_world [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_cmd   <= s2_cmd;
      s3_zero  <= s2_zero;
      s3_index <= s2_index;
      s3_color <= s2_color;
      s3_camz  <= s2_camz;
      s3_nu    <= 51'(s2_mu1) + 51'(s2_mu2);
      s3_nv    <= 51'(s2_mv1) + 51'(s2_mv2);
      s3_world <= world_next;
    end
  end

  // ---------------- stage 4: magnitudes for the divider ----------------
  // trunc(n / (d*1024)) == floor(floor(|n|/1024) / |d|) with sign fixup
  logic [50:0] mag_u, mag_v;
  logic [24:0] mag_d;
  assign mag_u = s3_nu[50] ? 51'(-s3_nu) : 51'(s3_nu);
  assign mag_v = s3_nv[50] ? 51'(-s3_nv) : 51'(s3_nv);
  assign mag_d = s3_camz[24] ? 25'(-s3_camz) : 25'(s3_camz);

  lpc_pkg::side_t s4_side;
  logic [NW-1:0]  s4_nu, s4_nv;
  logic [DW-1:0]  s4_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_side.valid <= 1'b0;
    end else if (advance) begin
      s4_side.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_side.cmd         <= s3_cmd;
      s4_side.pixel_index <= s3_index;
      s4_side.pixel_color <= s3_color;
      s4_side.zero_pt     <= s3_zero;
      s4_side.depth_zero  <= (s3_camz == '0);
      s4_side.wx          <= s3_world[0];
      s4_side.wy          <= s3_world[1];
      s4_side.wz          <= s3_world[2];
      s4_side.neg_u       <= s3_nu[50] ^ s3_camz[24];
      s4_side.neg_v       <= s3_nv[50] ^ s3_camz[24];
      s4_nu               <= mag_u[NW+9:10];
      s4_nv               <= mag_v[NW+9:10];
      s4_d                <= mag_d[DW-1:0];
    end
  end

  // ---------------- divider, side-band delay ----------------
  logic [NW-1:0] qu, qv;

  lpc_div #(.NUM_W(NW), .DEN_W(DW)) u_div_u (
    .clk (clk),
    .en  (advance),
    .num (s4_nu),
    .den (s4_d),
    .quo (qu)
  );

  lpc_div #(.NUM_W(NW), .DEN_W(DW)) u_div_v (
    .clk (clk),
    .en  (advance),
    .num (s4_nv),
    .den (s4_d),
    .quo (qv)
  );

  lpc_pkg::side_t dly [NW+1];
  assign dly[0] = s4_side;

  for (genvar i = 0; i < NW; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        dly[i+1].valid <= 1'b0;
      end else if (advance) begin
        dly[i+1].valid <= dly[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dly[i+1].cmd         <= dly[i].cmd;
        dly[i+1].pixel_index <= dly[i].pixel_index;
        dly[i+1].pixel_color <= dly[i].pixel_color;
        dly[i+1].zero_pt     <= dly[i].zero_pt;
        dly[i+1].depth_zero  <= dly[i].depth_zero;
        dly[i+1].wx          <= dly[i].wx;
        dly[i+1].wy          <= dly[i].wy;
        dly[i+1].wz          <= dly[i].wz;
        dly[i+1].neg_u       <= dly[i].neg_u;
        dly[i+1].neg_v       <= dly[i].neg_v;
      end
    end
  end

  lpc_pkg::side_t dv_side;
  assign dv_side = dly[NW];

  // ---------------- stage 5: signed pixel coordinates ----------------
  lpc_pkg::side_t     s5_side;
  logic signed [NW:0] s5_u, s5_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_side.valid <= 1'b0;
    end else if (advance) begin
      s5_side.valid <= dv_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_side.cmd         <= dv_side.cmd;
      s5_side.pixel_index <= dv_side.pixel_index;
      s5_side.pixel_color <= dv_side.pixel_color;
      s5_side.zero_pt     <= dv_side.zero_pt;
      s5_side.depth_zero  <= dv_side.depth_zero;
      s5_side.wx          <= dv_side.wx;
      s5_side.wy          <= dv_side.wy;
      s5_side.wz          <= dv_side.wz;
      s5_side.neg_u       <= dv_side.neg_u;
      s5_side.neg_v       <= dv_side.neg_v;
      s5_u <= dv_side.neg_u ? -$signed({1'b0, qu}) : $signed({1'b0, qu});
      s5_v <= dv_side.neg_v ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    end
  end

  // ---------------- stage 6: row offset v*width ----------------
  localparam int unsigned VW_W = NW + 15;

  lpc_pkg::side_t       s6_side;
  logic signed [VW_W-1:0] s6_vw;
  logic signed [NW:0]     s6_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_side.valid <= 1'b0;
    end else if (advance) begin
      s6_side.valid <= s5_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_side.cmd         <= s5_side.cmd;
      s6_side.pixel_index <= s5_side.pixel_index;
      s6_side.pixel_color <= s5_side.pixel_color;
      s6_side.zero_pt     <= s5_side.zero_pt;
      s6_side.depth_zero  <= s5_side.depth_zero;
      s6_side.wx          <= s5_side.wx;
      s6_side.wy          <= s5_side.wy;
      s6_side.wz          <= s5_side.wz;
      s6_side.neg_u       <= s5_side.neg_u;
      s6_side.neg_v       <= s5_side.neg_v;
      s6_vw <= VW_W'(s5_v * $signed({1'b0, width}));
      s6_u  <= s5_u;
    end
  end

  // ---------------- stage 7: index check, store address ----------------
  logic signed [VW_W:0] idx;
  logic                 idx_ok, load_ok;
  assign idx     = (VW_W+1)'(s6_vw) + (VW_W+1)'(s6_u);
  assign idx_ok  = !idx[VW_W]
                && (idx < $signed((VW_W+1)'(area)))
                && (idx < $signed((VW_W+1)'(IMAGE_PIXELS)));
  assign load_ok = ({3'b000, s6_side.pixel_index} < 25'(IMAGE_PIXELS));

  lpc_pkg::side_t s7_side;
  logic           s7_hit, s7_load_ok;
  logic [AW-1:0]  s7_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_side.valid <= 1'b0;
    end else if (advance) begin
      s7_side.valid <= s6_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s7_side.cmd         <= s6_side.cmd;
      s7_side.pixel_index <= s6_side.pixel_index;
      s7_side.pixel_color <= s6_side.pixel_color;
      s7_side.zero_pt     <= s6_side.zero_pt;
      s7_side.depth_zero  <= s6_side.depth_zero;
      s7_side.wx          <= s6_side.wx;
      s7_side.wy          <= s6_side.wy;
      s7_side.wz          <= s6_side.wz;
      s7_side.neg_u       <= s6_side.neg_u;
      s7_side.neg_v       <= s6_side.neg_v;
      s7_hit     <= idx_ok && !s6_side.depth_zero && !s6_side.zero_pt;
      s7_load_ok <= load_ok;
      s7_addr    <= (s6_side.cmd == lpc_pkg::CMD_LOAD)
                    ? AW'(s6_side.pixel_index) : AW'(idx);
    end
  end

  // ---------------- image store ----------------
  // loads write here in request order, so later points see them
  logic [23:0] pix;
  logic        store_we;
  assign store_we = s7_side.valid && (s7_side.cmd == lpc_pkg::CMD_LOAD) && s7_load_ok;

  lpc_ram #(.WIDTH(24), .DEPTH(IMAGE_PIXELS)) u_store (
    .clk   (clk),
    .en    (advance),
    .we    (store_we),
    .waddr (s7_addr),
    .wdata (s7_side.pixel_color),
    .raddr (s7_addr),
    .rdata (pix)
  );

  // ---------------- stage 8: aligned with store read data ----------------
  logic               s8_valid, s8_point, s8_zero, s8_hit;
  logic signed [23:0] s8_wx, s8_wy, s8_wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (advance) begin
      s8_valid <= s7_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s8_point <= (s7_side.cmd == lpc_pkg::CMD_PROJECT);
      s8_zero  <= s7_side.zero_pt;
      s8_hit   <= s7_hit;
      s8_wx    <= s7_side.wx;
      s8_wy    <= s7_side.wy;
      s8_wz    <= s7_side.wz;
    end
  end

  // ---------------- output register ----------------
  logic colored;
  assign colored = s8_hit && (pix != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= s8_valid && s8_point;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s8_zero) begin
        m_axis_tuser <= lpc_pkg::ST_ZERO_PT;
        m_axis_tdata <= '0;
      end else if (colored) begin
        m_axis_tuser <= lpc_pkg::ST_COLORED;
        m_axis_tdata <= {pix, s8_wz, s8_wy, s8_wx};
      end else begin
        m_axis_tuser <= lpc_pkg::ST_NO_COLOR;
        m_axis_tdata <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream bench for the lidar point colorizer
// Loads small images, projects points through several camera and pose
// settings, and checks every result against an in-bench projection model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int LATENCY   = 47;
  localparam longint LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [62:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [23:0] wx;
    logic signed [23:0] wy;
    logic signed [23:0] wz;
    logic [7:0]         c0;
    logic [7:0]         c1;
    logic [7:0]         c2;
  } color_result_t;

  lidar_point_colorizer uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block's configuration and image
  logic [47:0]   rot_row [3];
  logic [62:0]   shift_reg;
  logic [47:0]   focal_reg, princ_reg;
  logic [12:0]   width_reg, height_reg;
  logic [23:0]   image_mem [int];

  // expected results in request order, head/tail counters
  color_result_t expected_colors [int];
  int            exp_head = 0;
  int            exp_tail = 0;
  int            mismatch_count = 0;
  bit            idle_enable = 1'b1;
  longint        cycle_count = 0;

  function automatic logic signed [23:0] rotate_coord(int row, int k,
      longint x, longint y, longint z);
    longint acc, lim_hi, lim_lo;
    lim_hi = 8388607;
    lim_lo = -8388608;
    acc = longint'($signed(rot_row[row][15:0])) * x
        + longint'($signed(rot_row[row][31:16])) * y
        + longint'($signed(rot_row[row][47:32])) * z;
    acc += longint'($signed(shift_reg[21*k +: 21])) * 16384;
    acc = (acc + 8192) >>> 14;  // arithmetic shift floors
    if (acc > lim_hi) acc = lim_hi;
    if (acc < lim_lo) acc = lim_lo;
    return acc[23:0];
  endfunction

  // projection of one point; returns the result it should give
  function automatic color_result_t project_point(logic [23:0] px, logic [23:0] py,
      logic [23:0] pz);
    color_result_t r;
    longint x, y, z, cx, cy, cz, den, u, v, idx;
    logic [23:0] pix;
    r = '0;
    x = longint'($signed(px));
    y = longint'($signed(py));
    z = longint'($signed(pz));
    if (x == 0 && y == 0 && z == 0) begin
      r.status = lpc_pkg::ST_ZERO_PT;
      return r;
    end
    r.status = lpc_pkg::ST_NO_COLOR;
    cx = -y;
    cy = -z;
    cz = x + 102;
    if (cz == 0) return r;
    den = cz * 1024;
    // SV division truncates toward zero, as required
    u = (longint'(focal_reg[23:0]) * cx + longint'(princ_reg[23:0]) * cz) / den;
    v = (longint'(focal_reg[47:24]) * cy + longint'(princ_reg[47:24]) * cz) / den;
    idx = v * longint'(width_reg) + u;
    if (idx < 0 || idx >= longint'(width_reg) * longint'(height_reg)
        || idx >= longint'(lpc_pkg::IMAGE_PIXELS)) return r;
    if (!image_mem.exists(int'(idx))) return r;
    pix = image_mem[int'(idx)];
    if (pix == 0) return r;
    r.status = lpc_pkg::ST_COLORED;
    r.wx = rotate_coord(0, 0, x, y, z);
    r.wy = rotate_coord(1, 1, x, y, z);
    r.wz = rotate_coord(2, 2, x, y, z);
    r.c0 = pix[7:0];
    r.c1 = pix[15:8];
    r.c2 = pix[23:16];
    return r;
  endfunction

  // true when the point would look up a pixel that was never loaded
  function automatic bit unloaded_hit(logic [23:0] px, logic [23:0] py,
      logic [23:0] pz);
    longint x, y, z, cz, den, u, v, idx;
    x = longint'($signed(px));
    y = longint'($signed(py));
    z = longint'($signed(pz));
    if (x == 0 && y == 0 && z == 0) return 1'b0;
    cz = x + 102;
    if (cz == 0) return 1'b0;
    den = cz * 1024;
    u = (longint'(focal_reg[23:0]) * -y + longint'(princ_reg[23:0]) * cz) / den;
    v = (longint'(focal_reg[47:24]) * -z + longint'(princ_reg[47:24]) * cz) / den;
    idx = v * longint'(width_reg) + u;
    if (idx < 0 || idx >= longint'(width_reg) * longint'(height_reg)
        || idx >= longint'(lpc_pkg::IMAGE_PIXELS)) return 1'b0;
    return !image_mem.exists(int'(idx));
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 16)) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [62:0] val);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lpc_pkg::REG_ROT_ROW0:  rot_row[0] = val[47:0];
      lpc_pkg::REG_ROT_ROW1:  rot_row[1] = val[47:0];
      lpc_pkg::REG_ROT_ROW2:  rot_row[2] = val[47:0];
      lpc_pkg::REG_SHIFT:     shift_reg  = val;
      lpc_pkg::REG_FOCAL:     focal_reg  = val[47:0];
      lpc_pkg::REG_PRINCIPAL: princ_reg  = val[47:0];
      lpc_pkg::REG_WIDTH:     width_reg  = val[12:0];
      default:                height_reg = val[12:0];
    endcase
  endtask

  // one request; expectation is computed at acceptance, in order.
  // tvalid stays high after acceptance; the next request replaces it, and an
  // idle burst, a register write or a drain takes it down.
  task automatic send_request(logic cmd, logic [21:0] pidx, logic [23:0] pcol,
      logic [23:0] px, logic [23:0] py, logic [23:0] pz);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      idle_burst();
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'd0, pz, py, px, pcol, pidx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (cmd == lpc_pkg::CMD_LOAD) begin
      if (pidx < lpc_pkg::IMAGE_PIXELS) begin
        image_mem[int'(pidx)] = pcol;
      end
    end else begin
      expected_colors[exp_tail] = project_point(px, py, pz);
      exp_tail++;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (exp_head != exp_tail) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // back-project pixel (u,v) at depth x so the point lands on it
  task automatic aim_point(int u, int v, output logic [23:0] px,
      output logic [23:0] py, output logic [23:0] pz);
    longint x, cz, fx, fy, ccx, ccy, y, z;
    x = $urandom_range(1000, 20000);
    cz = x + 102;
    fx = focal_reg[23:0];
    fy = focal_reg[47:24];
    ccx = princ_reg[23:0];
    ccy = princ_reg[47:24];
    y = 0;
    z = 0;
    if (fx != 0) y = -(((longint'(u) * 1024 + 512) * cz - ccx * cz) / fx);
    if (fy != 0) z = -(((longint'(v) * 1024 + 512) * cz - ccy * cz) / fy);
    px = x[23:0];
    py = y[23:0];
    pz = z[23:0];
  endtask

  function automatic logic [23:0] any24();
    case ($urandom_range(0, 3))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom());
    endcase
  endfunction

  // small camera, moderate focal length, center principal point
  task automatic set_camera(int w, int h);
    write_reg(lpc_pkg::REG_FOCAL, 63'({24'd40960, 24'd40960}));
    write_reg(lpc_pkg::REG_PRINCIPAL, 63'({24'(h * 512), 24'(w * 512)}));
    write_reg(lpc_pkg::REG_WIDTH, 63'(w));
    write_reg(lpc_pkg::REG_HEIGHT, 63'(h));
  endtask

  task automatic load_image(int w, int h);
    logic [23:0] c;
    for (int i = 0; i < w * h; i++) begin
      c = 24'($urandom());
      if ($urandom_range(0, 9) == 0) c = 24'd0;  // some black pixels
      send_request(lpc_pkg::CMD_LOAD, 22'(i), c, any24(), any24(), any24());
    end
  endtask

  task automatic test_directed();
    logic [23:0] px, py, pz;
    write_reg(lpc_pkg::REG_ROT_ROW0, 63'({16'sd0, 16'sd0, 16'sd16384}));
    write_reg(lpc_pkg::REG_ROT_ROW1, 63'({16'sd0, 16'sd16384, 16'sd0}));
    write_reg(lpc_pkg::REG_ROT_ROW2, 63'({16'sd16384, 16'sd0, 16'sd0}));
    write_reg(lpc_pkg::REG_SHIFT, {21'sd1024, -21'sd2048, 21'sd0});
    set_camera(8, 4);
    load_image(8, 4);
    send_request(lpc_pkg::CMD_LOAD, 22'h3FFFFF, 24'hFFFFFF, '0, '0, '0);  // max index
    send_request(lpc_pkg::CMD_LOAD, 22'd5, 24'h123456, '0, '0, '0);
    send_request(lpc_pkg::CMD_PROJECT, '0, '0, 24'd0, 24'd0, 24'd0);     // zero point
    send_request(lpc_pkg::CMD_PROJECT, '0, '0, -24'sd102, 24'd5, 24'd7); // zero depth
    send_request(lpc_pkg::CMD_PROJECT, '0, '0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_request(lpc_pkg::CMD_PROJECT, '0, '0, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_request(lpc_pkg::CMD_PROJECT, '0, '0, -24'sd5000, 24'd300, 24'd100);  // behind
    aim_point(5, 0, px, py, pz);
    send_request(lpc_pkg::CMD_PROJECT, '0, '0, px, py, pz);
    aim_point(7, 3, px, py, pz);
    send_request(lpc_pkg::CMD_PROJECT, '0, '0, px, py, pz);
    aim_point(9, 3, px, py, pz);  // index past the image
    send_request(lpc_pkg::CMD_PROJECT, '0, '0, px, py, pz);
    drain();
  endtask

  // saturating pose, extreme rotation and translation
  task automatic test_saturation();
    logic [23:0] px, py, pz;
    write_reg(lpc_pkg::REG_ROT_ROW0, 63'({16'h7FFF, 16'h7FFF, 16'h7FFF}));
    write_reg(lpc_pkg::REG_ROT_ROW1, 63'({16'h8000, 16'h8000, 16'h8000}));
    write_reg(lpc_pkg::REG_ROT_ROW2, 63'hFFFF_FFFF_FFFF);
    write_reg(lpc_pkg::REG_SHIFT, {21'h0FFFFF, 21'h100000, 21'h1FFFFF});
    for (int i = 0; i < 20; i++) begin
      aim_point($urandom_range(0, 7), $urandom_range(0, 3), px, py, pz);
      if (i < 10) px = 24'h7FFFFF - 24'($urandom_range(0, 3));
      send_request(lpc_pkg::CMD_PROJECT, '0, '0, px, py, pz);
    end
    drain();
  endtask

  // degenerate camera: zero width, all-ones intrinsics, then zero height and zero intrinsics
  task automatic test_degenerate();
    logic [23:0] px, py, pz;
    write_reg(lpc_pkg::REG_WIDTH, 63'd0);
    for (int i = 0; i < 6; i++)
      send_request(lpc_pkg::CMD_PROJECT, '0, '0, any24(), any24(), any24());
    drain();
    write_reg(lpc_pkg::REG_WIDTH, 63'd4096);
    write_reg(lpc_pkg::REG_HEIGHT, 63'd4096);
    write_reg(lpc_pkg::REG_FOCAL, 63'hFFFF_FFFF_FFFF);
    write_reg(lpc_pkg::REG_PRINCIPAL, 63'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 10; i++) begin
      // keep clear of pixels that were never loaded
      do begin
        px = any24();
        py = any24();
        pz = any24();
      end while (unloaded_hit(px, py, pz));
      send_request(lpc_pkg::CMD_PROJECT, '0, '0, px, py, pz);
    end
    drain();
    write_reg(lpc_pkg::REG_HEIGHT, 63'd0);
    write_reg(lpc_pkg::REG_FOCAL, 63'd0);
    write_reg(lpc_pkg::REG_PRINCIPAL, 63'd0);
    drain();
  endtask

  // random traffic over a fresh small image with random pose
  task automatic test_random(int w, int h, int n);
    logic [23:0] px, py, pz;
    int sel;
    write_reg(lpc_pkg::REG_ROT_ROW0, 63'({$urandom(), $urandom()}));
    write_reg(lpc_pkg::REG_ROT_ROW1, 63'({$urandom(), $urandom()}));
    write_reg(lpc_pkg::REG_ROT_ROW2, 63'({$urandom(), $urandom()}));
    write_reg(lpc_pkg::REG_SHIFT, 63'({$urandom(), $urandom()}));
    set_camera(w, h);
    load_image(w, h);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) begin
        aim_point($urandom_range(0, w - 1), $urandom_range(0, h - 1), px, py, pz);
        send_request(lpc_pkg::CMD_PROJECT, '0, '0, px, py, pz);
      end else if (sel < 15) begin
        // reload a pixel already in the image
        send_request(lpc_pkg::CMD_LOAD, 22'($urandom_range(0, w * h - 1)),
                     24'($urandom()), any24(), any24(), any24());
      end else if (sel < 16) begin
        send_request(lpc_pkg::CMD_PROJECT, '0, '0, '0, '0, '0);
      end else begin
        send_request(lpc_pkg::CMD_PROJECT, '0, '0, any24(), any24(), any24());
      end
    end
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    color_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24],
             m_axis_tdata[71:48], m_axis_tdata[79:72], m_axis_tdata[87:80],
             m_axis_tdata[95:88]};
      if (exp_head == exp_tail) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_colors[exp_head];
        expected_colors.delete(exp_head);
        exp_head++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: st %0d/%0d w %h %h %h / %h %h %h c %h%h%h / %h%h%h",
                     want.status, got.status, want.wx, want.wy, want.wz,
                     got.wx, got.wy, got.wz, want.c2, want.c1, want.c0,
                     got.c2, got.c1, got.c0);
        end
      end
    end
  end

  // result-side back-pressure in bursts
  initial begin
    @(negedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (idle_enable) begin
        m_axis_tready <= 1'b0;
        idle_burst();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rot_row = '{default: '0};
    shift_reg = '0;
    focal_reg = '0;
    princ_reg = '0;
    width_reg = 13'd1;
    height_reg = 13'd1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_degenerate();
    test_random(16, 12, 300);
    test_random(12, 9, 200);
    idle_enable = 1'b0;
    test_random(10, 8, 150);
    if (mismatch_count == 0 && exp_head == exp_tail) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
